// ===== hdl/rau_pkg.sv =====
// shared types and constants for the rational arithmetic unit
package rau_pkg;
	localparam int FieldBits = 16;
	localparam int DefWidth = 16;
	localparam int NumBits = 33;
	localparam int DenBits = 32;

	// operation codes
	localparam logic [2:0] OpAdd = 3'd0;
	localparam logic [2:0] OpSub = 3'd1;
	localparam logic [2:0] OpDiv = 3'd2;
	localparam logic [2:0] OpEqu = 3'd3;
	localparam logic [2:0] OpRed = 3'd4;

	// status codes
	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StZeroDen = 2'd1;
	localparam logic [1:0] StDivZero = 2'd2;
endpackage

// ===== hdl/rational_arith_unit.sv =====
// rational arithmetic unit: add, subtract, divide, equal test and reduce with gcd
//
//  channel | dir | signals               | contents
//  s_axis  | in  | tvalid tready tdata   | operation, a_num, a_den, b_num, b_den
//  m_axis  | out | tvalid tready tdata   | result_num, result_den, is_equal, status
//
// add, subtract and divide run on one 17x17 multiplier, which is shared
// over the cross products. equal and reduce run euclid on a shared restoring divider (a
// set-up state, then shift steps per remainder or quotient). one item at a time;
// s_axis_tready is low while busy or while a result waits. reset clears the sequencer only.
module rational_arith_unit
	import rau_pkg::*;
#(
	parameter int WIDTH = DefWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] operation, [18:3] a_num, [34:19] a_den, [50:35] b_num, [66:51] b_den
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [32:0] result_num, [64:33] result_den, [65] is_equal, [67:66] status
	output logic [71:0] m_axis_tdata
);
	localparam int W = (WIDTH < FieldBits) ? WIDTH : FieldBits;
	localparam int XB = 17;            // magnitude working width
	localparam int CB = 5;             // bit counter

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_SUM, S_GSTART, S_DIV, S_GSTEP,
		S_QSTART, S_QDIV, S_QDONE, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	logic signed [XB-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [XB-1:0] rn_a_q, rd_a_q;   // reduced a during equal
	logic signed [34:0] p_q;                // first product
	logic signed [NumBits-1:0] rnum_q;
	logic signed [DenBits-1:0] rden_q;
	logic eq_q;
	logic [1:0] st_q;
	logic second_q;                         // working on b
	logic qden_q;                           // quotient pass on denominator
	// gcd and divider
	logic signed [XB-1:0] gx_q, gy_q, gg_q;
	logic [XB-1:0] dvd_q, dvs_q;
	logic [XB-1:0] rem_q;
	logic [CB-1:0] cnt_q;
	logic neg_q;

	// operand narrowing
	function automatic logic signed [XB-1:0] narrow(input logic [FieldBits-1:0] raw);
		logic [W-1:0] v;
		begin
			v = raw[W-1:0];
			narrow = XB'($signed(v));
		end
	endfunction

	// shared multiplier
	logic signed [XB-1:0] mx, my;
	logic signed [33:0] mp;
	always_comb begin
		mx = an_q;
		my = bd_q;
		if (state_q == S_MUL2) begin
			mx = (op_q == OpDiv) ? ad_q : bn_q;
			my = (op_q == OpDiv) ? bn_q : ad_q;
		end else if (state_q == S_SUM) begin
			mx = ad_q;
			my = bd_q;
		end
		mp = mx * my;
	end

	// restoring divider step on magnitudes
	logic [XB:0] rsh, rsub;
	always_comb begin
		rsh = {rem_q, dvd_q[XB-1]};
		rsub = rsh - {1'b0, dvs_q};
	end

	function automatic logic [XB-1:0] mag(input logic signed [XB-1:0] v);
		mag = v[XB-1] ? XB'(-v) : v;
	endfunction

	logic in_go;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_go = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {4'd0, st_q, eq_q, rden_q, rnum_q};

	logic signed [XB-1:0] nan, nad, nbn, nbd;
	assign nan = narrow(s_axis_tdata[18:3]);
	assign nad = narrow(s_axis_tdata[34:19]);
	assign nbn = narrow(s_axis_tdata[50:35]);
	assign nbd = narrow(s_axis_tdata[66:51]);

	// incoming operation and its zero denominator check
	logic [2:0] in_op;
	logic in_zden;
	assign in_op = s_axis_tdata[2:0];
	assign in_zden = (in_op == OpRed) ? (nad == 0)
		: ((in_op inside {OpAdd, OpSub, OpDiv, OpEqu}) && (nad == 0 || nbd == 0));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_go) begin
						op_q <= in_op;
						an_q <= nan; ad_q <= nad; bn_q <= nbn; bd_q <= nbd;
						rnum_q <= '0; rden_q <= '0; eq_q <= 1'b0;
						second_q <= 1'b0;
						if (in_zden) begin
							st_q <= StZeroDen;
							state_q <= S_OUT;
						end else if (in_op == OpDiv && nbn == 0) begin
							st_q <= StDivZero;
							state_q <= S_OUT;
						end else begin
							st_q <= StOk;
							if (in_op inside {OpEqu, OpRed}) state_q <= S_GSTART;
							else if (in_op inside {OpAdd, OpSub, OpDiv}) state_q <= S_MUL1;
							else state_q <= S_OUT;
						end
					end
				end
				S_MUL1: begin
					p_q <= 35'(mp);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (op_q == OpDiv) begin
						rnum_q <= NumBits'(p_q);
						rden_q <= DenBits'(mp);
						state_q <= S_OUT;
					end else begin
						p_q <= (op_q == OpSub) ? p_q - 35'(mp) : p_q + 35'(mp);
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					rnum_q <= NumBits'(p_q);
					rden_q <= DenBits'(mp);
					state_q <= S_OUT;
				end
				// euclid on current rational
				S_GSTART: begin
					gx_q <= second_q ? bn_q : an_q;
					gy_q <= second_q ? bd_q : ad_q;
					state_q <= S_GSTEP;
				end
				S_GSTEP: begin
					if (gy_q == 0) begin
						gg_q <= gx_q;
						qden_q <= 1'b0;
						state_q <= S_QSTART;
					end else begin
						dvd_q <= mag(gx_q);
						dvs_q <= mag(gy_q);
						neg_q <= gx_q[XB-1];
						rem_q <= '0;
						cnt_q <= CB'(XB);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dvd_q <= {dvd_q[XB-2:0], ~rsub[XB]};
					rem_q <= rsub[XB] ? rsh[XB-1:0] : rsub[XB-1:0];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 1) begin
						// remainder takes the dividend's sign
						gx_q <= gy_q;
						gy_q <= neg_q ? -$signed((rsub[XB] ? rsh[XB-1:0] : rsub[XB-1:0]))
							: $signed((rsub[XB] ? rsh[XB-1:0] : rsub[XB-1:0]));
						state_q <= S_GSTEP;
					end
				end
				// divide numerator then denominator by gcd
				S_QSTART: begin
					dvd_q <= mag(qden_q ? (second_q ? bd_q : ad_q) : (second_q ? bn_q : an_q));
					dvs_q <= mag(gg_q);
					neg_q <= (qden_q ? (second_q ? bd_q[XB-1] : ad_q[XB-1])
						: (second_q ? bn_q[XB-1] : an_q[XB-1])) ^ gg_q[XB-1];
					rem_q <= '0;
					cnt_q <= CB'(XB);
					state_q <= S_QDIV;
				end
				S_QDIV: begin
					dvd_q <= {dvd_q[XB-2:0], ~rsub[XB]};
					rem_q <= rsub[XB] ? rsh[XB-1:0] : rsub[XB-1:0];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 1) state_q <= S_QDONE;
				end
				S_QDONE: begin
					if (!qden_q) begin
						gx_q <= neg_q ? $signed(XB'(-dvd_q)) : $signed(dvd_q);
						qden_q <= 1'b1;
						state_q <= S_QSTART;
					end else begin
						gy_q <= neg_q ? $signed(XB'(-dvd_q)) : $signed(dvd_q);
						state_q <= S_FIN;
					end
				end
				// sign normalise and finish
				S_FIN: begin
					if (op_q == OpRed) begin
						rnum_q <= NumBits'(gy_q[XB-1] ? -gx_q : gx_q);
						rden_q <= DenBits'(gy_q[XB-1] ? -gy_q : gy_q);
						state_q <= S_OUT;
					end else if (!second_q) begin
						rn_a_q <= gy_q[XB-1] ? -gx_q : gx_q;
						rd_a_q <= gy_q[XB-1] ? -gy_q : gy_q;
						second_q <= 1'b1;
						state_q <= S_GSTART;
					end else begin
						eq_q <= (rn_a_q == (gy_q[XB-1] ? -gx_q : gx_q))
							&& (rd_a_q == (gy_q[XB-1] ? -gy_q : gy_q));
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while result pending");
	a_eqonly: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[65] |-> op_q == OpEqu && st_q == StOk)
		else $error("equal flag outside equal test");
endmodule

// ===== tb/rational_arith_unit_tb.sv =====
// testbench for the rational arithmetic unit: random and directed items checked against a predictor
`timescale 1ns / 100ps

module rational_arith_unit_tb;
	import rau_pkg::*;

	// members listed from the highest bits down, so op lands in the lowest bits
	typedef struct packed {
		logic [15:0] bd, bn, ad, an;
		logic [2:0]  op;
	} rat_item_t;

	typedef struct packed {
		logic [1:0]  st;
		logic        eq;
		logic [31:0] den;
		logic [32:0] num;
	} rat_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;

	rat_item_t pending_items[$];
	rat_res_t  expected_results[$];
	int        n_mismatch = 0;
	int        n_checked = 0;
	int        n_sent = 0;
	int        idle_cycles = 0;
	int        send_wait = 0;
	int        recv_wait = 0;
	bit        stim_done = 0;
	bit        hold_off = 0;
	int        op_seen[8];

	rational_arith_unit dut (.*);

	always #2 clk = ~clk;

	// euclid with truncating remainder
	function automatic longint gcd_trunc(longint x, longint y);
		longint t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// build one item from its fields
	function automatic rat_item_t mk_item(logic [2:0] op, logic [15:0] an, logic [15:0] ad,
		logic [15:0] bn, logic [15:0] bd);
		rat_item_t it;
		it.op = op;
		it.an = an;
		it.ad = ad;
		it.bn = bn;
		it.bd = bd;
		return it;
	endfunction

	// expected result of one item
	function automatic rat_res_t rational_result(rat_item_t it);
		rat_res_t r;
		longint an, ad, bn, bd, rn, rd, g;
		an = longint'(signed'(it.an));
		ad = longint'(signed'(it.ad));
		bn = longint'(signed'(it.bn));
		bd = longint'(signed'(it.bd));
		rn = 0;
		rd = 0;
		r = '0;
		if (it.op <= OpRed) begin
			if (ad == 0 || (it.op != OpRed && bd == 0)) begin
				r.st = StZeroDen;
			end else if (it.op == OpAdd) begin
				rn = an * bd + bn * ad;
				rd = ad * bd;
			end else if (it.op == OpSub) begin
				rn = an * bd - bn * ad;
				rd = ad * bd;
			end else if (it.op == OpDiv) begin
				if (bn == 0) begin
					r.st = StDivZero;
				end else begin
					rn = an * bd;
					rd = ad * bn;
				end
			end else begin
				g = gcd_trunc(an, ad);
				an = an / g;
				ad = ad / g;
				if (ad < 0) begin
					an = -an;
					ad = -ad;
				end
				if (it.op == OpRed) begin
					rn = an;
					rd = ad;
				end else begin
					g = gcd_trunc(bn, bd);
					bn = bn / g;
					bd = bd / g;
					if (bd < 0) begin
						bn = -bn;
						bd = -bd;
					end
					r.eq = (an == bn && ad == bd);
				end
			end
		end
		r.num = rn[32:0];
		r.den = rd[31:0];
		return r;
	endfunction

	function automatic logic [15:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(signed'($urandom_range(0, 14)) - 7);
			3: return 16'(signed'($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic rat_item_t rand_item();
		rat_item_t it;
		it.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		it.an = rand_val();
		it.ad = rand_val();
		it.bn = rand_val();
		it.bd = rand_val();
		// equal test on proportional operands
		if (it.op == OpEqu && $urandom_range(0, 1)) begin
			it.an = 16'(signed'($urandom_range(0, 60)) - 30);
			it.ad = 16'(signed'($urandom_range(1, 30)) * ($urandom_range(0, 1) ? 1 : -1));
			it.bn = 16'(signed'(it.an) * 3);
			it.bd = 16'(signed'(it.ad) * ($urandom_range(0, 1) ? 3 : -3));
			if ($urandom_range(0, 3) == 0)
				it.bn = -it.bn;
		end
		return it;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(rational_result(rat_item_t'(s_axis_tdata[66:0])));
				n_sent <= n_sent + 1;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (send_wait > 0 || hold_off || pending_items.size() == 0) begin
					s_axis_tvalid <= 1'b0;
					if (send_wait > 0)
						send_wait <= send_wait - 1;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'b0, pending_items.pop_front()};
					send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		rat_res_t got, exp_r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = rat_res_t'(m_axis_tdata[67:0]);
				n_checked <= n_checked + 1;
				if (expected_results.size() == 0) begin
					n_mismatch <= n_mismatch + 1;
					if (n_mismatch < 10)
						$display("unexpected result %h", got);
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						n_mismatch <= n_mismatch + 1;
						if (n_mismatch < 10)
							$display("mismatch: num exp %h got %h, den exp %h got %h, eq %b/%b, st %0d/%0d",
								exp_r.num, got.num, exp_r.den, got.den, exp_r.eq, got.eq,
								exp_r.st, got.st);
					end
				end
			end
			if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				m_axis_tready <= 1'b0;
			end else if (m_axis_tvalid && m_axis_tready) begin
				recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("timeout");
			$display("Simulation FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		rat_item_t it;
		logic [15:0] ext[4];
		ext = '{16'sh8000, 16'sh7fff, 16'h0000, 16'hffff};
		for (int op = 0; op < 8; op++) begin
			it = mk_item(3'(op), ext[op % 4], ext[(op + 1) % 4], ext[(op + 2) % 4],
				ext[(op + 3) % 4]);
			pending_items.push_back(it);
		end
		pending_items.push_back(mk_item(OpAdd, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
		pending_items.push_back(mk_item(OpSub, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000));
		pending_items.push_back(mk_item(OpDiv, 16'd3, 16'd4, 16'd0, 16'd5));
		pending_items.push_back(mk_item(OpDiv, 16'd3, 16'd0, 16'd0, 16'd5));
		pending_items.push_back(mk_item(OpDiv, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff));
		pending_items.push_back(mk_item(OpEqu, 16'd2, 16'd4, 16'hffff, 16'hfffe));
		pending_items.push_back(mk_item(OpEqu, 16'd0, 16'd5, 16'd0, 16'hfffd));
		pending_items.push_back(mk_item(OpEqu, 16'sh8000, 16'sh8000, 16'd1, 16'd1));
		pending_items.push_back(mk_item(OpEqu, 16'd1, 16'd2, 16'd1, 16'd0));
		pending_items.push_back(mk_item(OpRed, 16'd6, 16'hfffc, 16'd0, 16'd0));
		pending_items.push_back(mk_item(OpRed, 16'd0, 16'hfff9, 16'd1, 16'd1));
		pending_items.push_back(mk_item(OpRed, 16'sh7fff, 16'sh8000, 16'd0, 16'd0));
		pending_items.push_back(mk_item(OpRed, 16'd5, 16'd0, 16'd0, 16'd0));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0);
		// drain fully before the random part
		@(posedge clk);
		hold_off <= 1'b1;
		wait (expected_results.size() == 0 && !s_axis_tvalid);
		@(posedge clk);
		hold_off <= 1'b0;
		for (int i = 0; i < 800; i++) begin
			it = rand_item();
			op_seen[it.op]++;
			pending_items.push_back(it);
		end
		wait (pending_items.size() == 0);
		@(posedge clk);
		wait (!s_axis_tvalid);
		wait (expected_results.size() == 0);
		repeat (1000) @(posedge clk);
		$display("%0d items sent, %0d results checked; random ops add %0d sub %0d div %0d",
			n_sent, n_checked, op_seen[OpAdd], op_seen[OpSub], op_seen[OpDiv]);
		$display("equal %0d reduce %0d unused codes %0d, with random source and sink stalls",
			op_seen[OpEqu], op_seen[OpRed], op_seen[5] + op_seen[6] + op_seen[7]);
		if (n_mismatch == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
